// ===== src/pixel_hue_replace_defines.svh =====
// Assertion macros for the hue replacement block
`ifndef PIXEL_HUE_REPLACE_DEFINES_SVH
`define PIXEL_HUE_REPLACE_DEFINES_SVH
// Implication checked every clock, off during reset
`define PHR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the clock after the antecedent
`define PHR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/phr_pkg.sv =====
// ----------------------------------------------------------------------------
// phr_pkg
// Constants and types shared by the hue replacement block.
// ----------------------------------------------------------------------------
package phr_pkg;
    localparam int DEF_FRAC_BITS = 16;
    localparam int CHAN_W        = 8;
    localparam int HUE_W         = 9;
    localparam int HUE_MAX       = 360;

    // One pixel request
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              last;
    } pix_t;
endpackage

// ===== src/phr_if.sv =====
// ----------------------------------------------------------------------------
// phr_if
// Valid/ready channel that carries one pixel request.
// ----------------------------------------------------------------------------
interface phr_if;
    import phr_pkg::*;
    logic valid;
    logic ready;
    pix_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/pixel_hue_replace.sv =====
// ----------------------------------------------------------------------------
// pixel_hue_replace
// Replaces the hue of each BGR pixel with a configured hue via HSL.
// ----------------------------------------------------------------------------
// channel   | dir | contents
// pix_in    | in  | blue, green, red, last (valid/ready)
// pix_out   | out | blue, green, red, last (valid/ready)
// cfg       | in  | cfg_we, cfg_wdata: target hue
//
// One pixel per clock while pix_out is not stalled.
// The saturation divider is a restoring divider, one quotient bit a stage.
// A stall freezes every stage at once; nothing is lost or repeated.
// Reset clears all valid bits and sets the target hue to 0.
module pixel_hue_replace
#(
    parameter int FRAC_BITS = phr_pkg::DEF_FRAC_BITS
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [phr_pkg::HUE_W-1:0] cfg_wdata,
    phr_if.sink                    pix_in,
    phr_if.source                  pix_out
);
    import phr_pkg::*;
    `include "pixel_hue_replace_defines.svh"

    localparam int F   = FRAC_BITS;
    localparam int W   = F + 2;          // fixed values up to 2*ONE
    localparam int PW  = 2 * W + 4;
    localparam int QB  = F + 1;          // quotient bits (S <= ONE)
    localparam int NSTG = QB + 7;
    localparam logic [W-1:0] ONE   = W'(1) << F;
    localparam logic [W-1:0] HALF  = W'(1) << (F - 1);
    localparam logic [W-1:0] THIRD = W'((64'd1 << F) / 3);
    localparam logic [W-1:0] TWO3  = W'((64'd2 << F) / 3);
    // hue * ONE / 360 as (hue * HK_MUL) >> 15, exact for hue <= 360
    localparam int HK_PW = F + 16;
    localparam longint unsigned HK_MUL = ((64'd1 << (F + 12)) + 64'd44) / 64'd45;

    // Per-stage payload
    typedef struct packed {
        pix_t          pix;
        logic          gray;
        logic [W-1:0]  l;
        logic [W-1:0]  diff;
        logic [W-1:0]  den;
        logic [W-1:0]  rem;
        logic [QB-1:0] quo;
        logic [W-1:0]  q;
        logic [W-1:0]  p;
        logic [W-1:0]  v0;
        logic [W-1:0]  v1;
        logic [W-1:0]  v2;
    } stg_t;

    logic [HUE_W-1:0] hue_reg;
    logic [W-1:0]     hk_reg, t0_reg, t1_reg, t2_reg;
    logic [NSTG-1:0]  vld_reg;
    stg_t             st_reg [NSTG];
    stg_t             st_next [NSTG];
    logic             adv;
    logic [W-1:0]     fx_tab [256];

    assign adv          = !vld_reg[NSTG-1] || pix_in.ready && 1'b0 || pix_out.ready;
    assign pix_in.ready = adv;
    assign pix_out.valid = vld_reg[NSTG-1];

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_reg <= '0;
        end
        else if (cfg_we)
        begin
            hue_reg <= (cfg_wdata > HUE_W'(HUE_MAX)) ? HUE_W'(HUE_MAX) : cfg_wdata;
        end
    end

    // Hue positions: hk_reg is registered from the hue register, then t0_reg..t2_reg from hk_reg
    always_ff @(posedge clk)
    begin
        hk_reg <= W'((HK_PW'(hue_reg) * HK_PW'(HK_MUL)) >> 15);
        t1_reg <= hk_reg;
        t0_reg <= (hk_reg + THIRD > ONE) ? hk_reg + THIRD - ONE : hk_reg + THIRD;
        t2_reg <= (hk_reg >= THIRD) ? hk_reg - THIRD : hk_reg + ONE - THIRD;
    end

    // Channel to fixed point: constant table of v * ONE / 255
    for (genvar i = 0; i < 256; i++)
    begin : g_fx
        assign fx_tab[i] = W'((64'(i) << F) / 64'd255);
    end

    function automatic logic [W-1:0] chan(input logic [W-1:0] t,
                                          input logic [W-1:0] p,
                                          input logic [W-1:0] q);
        logic [PW-1:0] d, x;
        d = PW'(q - p);
        if ({3'd0, t} * 6 < {3'd0, ONE})
            x = PW'(p) + ((d * PW'(t) * 6) >> F);
        else if ({1'b0, t} * 2 < {1'b0, ONE})
            x = PW'(q);
        else if ({2'd0, t} * 3 < {ONE, 1'b0})
            x = PW'(p) + ((d * PW'(TWO3 - t) * 6) >> F);
        else
            x = PW'(p);
        return W'(x);
    endfunction

    function automatic logic [CHAN_W-1:0] to8(input logic [W-1:0] v);
        logic [W+8:0] x;
        x = (({9'd0, v} * 255) >> F);
        return (x > 255) ? 8'hFF : x[7:0];
    endfunction

    // Pipeline next values
    always_comb
    begin
        logic [W-1:0] b, g, r, mx, mn, sum, l, dif;
        logic [2*W:0] lp;
        logic [W:0]   tr;
        st_next[0] = '0;
        for (int i = 1; i < NSTG; i++)
        begin
            st_next[i] = st_reg[i-1];
        end
        // Stage 0: fixed conversion, max/min, L, denominator
        b = fx_tab[pix_in.data.blue];
        g = fx_tab[pix_in.data.green];
        r = fx_tab[pix_in.data.red];
        mx = (g >= b) ? g : b;
        if (r > mx) mx = r;
        mn = (g <= b) ? g : b;
        if (r < mn) mn = r;
        sum = mx + mn;
        l = sum >> 1;
        dif = mx - mn;
        st_next[0].pix  = pix_in.data;
        st_next[0].gray = (pix_in.data.red == pix_in.data.green)
                          && (pix_in.data.green == pix_in.data.blue);
        st_next[0].l    = l;
        // dividend is dif << F: top bits start as the remainder, the rest
        // (dif LSB then F zeros) are shifted in one per stage
        st_next[0].rem  = dif >> 1;
        st_next[0].diff = {dif[0], {(W-1){1'b0}}};
        st_next[0].quo  = '0;
        if (l <= HALF)
            st_next[0].den = sum;
        else
            st_next[0].den = ((ONE << 1) > sum) ? (ONE << 1) - sum : '0;
        // Stages 1..QB: restoring division, one quotient bit each
        for (int k = 1; k <= QB; k++)
        begin
            tr = {st_reg[k-1].rem, st_reg[k-1].diff[W-1]};
            st_next[k].diff = st_reg[k-1].diff << 1;
            if (tr >= {1'b0, st_reg[k-1].den} && st_reg[k-1].den != '0)
            begin
                st_next[k].rem = W'(tr - {1'b0, st_reg[k-1].den});
                st_next[k].quo = {st_reg[k-1].quo[QB-2:0], 1'b1};
            end
            else
            begin
                st_next[k].rem = W'(tr);
                st_next[k].quo = {st_reg[k-1].quo[QB-2:0], 1'b0};
            end
        end
        // Stage QB+1: Q
        lp = '0;
        if (st_reg[QB].l < HALF)
        begin
            lp = ({{(W+1){1'b0}}, st_reg[QB].l} * (ONE + W'(st_reg[QB].quo))) >> F;
            st_next[QB+1].q = W'(lp);
        end
        else
        begin
            lp = ({{(W+1){1'b0}}, st_reg[QB].l} * W'(st_reg[QB].quo)) >> F;
            st_next[QB+1].q = st_reg[QB].l + W'(st_reg[QB].quo) - W'(lp);
        end
        // Stage QB+2: P
        if ({st_reg[QB+1].l, 1'b0} >= {1'b0, st_reg[QB+1].q})
            st_next[QB+2].p = W'({st_reg[QB+1].l, 1'b0} - {1'b0, st_reg[QB+1].q});
        else
            st_next[QB+2].p = '0;
        // Stage QB+3: clamp Q
        if (st_reg[QB+2].q < st_reg[QB+2].p)
            st_next[QB+3].q = st_reg[QB+2].p;
        // Stage QB+4: channel values
        st_next[QB+4].v0 = chan(t0_reg, st_reg[QB+3].p, st_reg[QB+3].q);
        st_next[QB+4].v1 = chan(t1_reg, st_reg[QB+3].p, st_reg[QB+3].q);
        st_next[QB+4].v2 = chan(t2_reg, st_reg[QB+3].p, st_reg[QB+3].q);
        // Stage QB+5: scale to 8 bits; gray pixels pass unchanged
        if (!st_reg[QB+4].gray)
        begin
            st_next[QB+5].pix.red   = to8(st_reg[QB+4].v0);
            st_next[QB+5].pix.green = to8(st_reg[QB+4].v1);
            st_next[QB+5].pix.blue  = to8(st_reg[QB+4].v2);
        end
    end

    // Stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], pix_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign pix_out.data = st_reg[NSTG-1].pix;

    `PHR_ASSERT_NEXT(a_stall_hold, pix_out.valid && !pix_out.ready,
        pix_out.valid && $stable(pix_out.data), "output changed under stall")
    `PHR_ASSERT_IMP(a_ready, !pix_out.valid, pix_in.ready, "pipe blocked while empty")
    `PHR_ASSERT_NEXT(a_hue_range, 1'b1, hue_reg <= HUE_W'(HUE_MAX), "hue out of range")
endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pixel_hue_replace. A fixed-point HSL model computes
// the expected pixel for each accepted request, and the monitor compares the
// results in order. The sender runs in bursts, the receiver stalls on its own
// pattern and holds off once for a long stretch to fill the pipeline.
// ----------------------------------------------------------------------------
module tb;
    import phr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB       = DEF_FRAC_BITS;
    localparam int WDOG_MAX = 20000;
    localparam int DRAIN    = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [HUE_W-1:0] cfg_wdata = '0;

    phr_if pix_in ();
    phr_if pix_out ();

    pixel_hue_replace #(.FRAC_BITS(FB)) DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .pix_in(pix_in.sink), .pix_out(pix_out.source)
    );

    always #5 clk = ~clk;

    pix_t pending_pix[$];
    pix_t expected_pix[$];
    logic [HUE_W-1:0] hue_reg = '0;
    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit timed_out = 1'b0;

    // Pixel channel value for one hue position
    function automatic logic [7:0] hue_channel(longint unsigned t, longint unsigned p,
                                               longint unsigned q);
        longint unsigned one;
        longint unsigned two3;
        longint unsigned v;
        one = 64'd1 << FB;
        two3 = (2 * one) / 3;
        if (t * 6 < one)
            v = p + (((q - p) * 6 * t) >> FB);
        else if (t * 2 < one)
            v = q;
        else if (t * 3 < 2 * one)
            v = p + (((q - p) * (two3 - t) * 6) >> FB);
        else
            v = p;
        v = (v * 255) >> FB;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // Expected output pixel for one input pixel at the current hue
    function automatic pix_t recolor(pix_t px, logic [HUE_W-1:0] hue);
        pix_t o;
        longint unsigned one, b, g, r, mx, mn, sum, l, den, s, q, p, h, hk, third;
        longint unsigned t0, t2;
        one = 64'd1 << FB;
        o = px;
        if (px.red == px.green && px.green == px.blue)
            return o;
        b = (longint'(px.blue) << FB) / 255;
        g = (longint'(px.green) << FB) / 255;
        r = (longint'(px.red) << FB) / 255;
        mx = (g >= b) ? g : b;
        if (r > mx) mx = r;
        mn = (g <= b) ? g : b;
        if (r < mn) mn = r;
        sum = mx + mn;
        l = sum >> 1;
        if (l <= one / 2)
            den = sum;
        else
            den = (2 * one > sum) ? 2 * one - sum : 0;
        s = (den != 0) ? ((mx - mn) << FB) / den : 0;
        if (l < one / 2)
            q = (l * (one + s)) >> FB;
        else
            q = l + s - ((l * s) >> FB);
        p = (2 * l >= q) ? 2 * l - q : 0;
        if (q < p) q = p;
        h = (hue > HUE_MAX) ? HUE_MAX : hue;
        hk = (h << FB) / HUE_MAX;
        third = one / 3;
        t0 = hk + third;
        if (t0 > one) t0 -= one;
        t2 = (hk >= third) ? hk - third : hk + one - third;
        o.red = hue_channel(t0, p, q);
        o.green = hue_channel(hk, p, q);
        o.blue = hue_channel(t2, p, q);
        return o;
    endfunction

    // Driver: bursts of requests with random gaps
    int burst_left = 0;
    int gap_left = 0;
    initial
    begin
        pix_in.valid = 1'b0;
        pix_in.data = '0;
    end
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_in.valid && pix_in.ready)
                expected_pix.push_back(recolor(pix_in.data, hue_reg));
            if (!pix_in.valid || pix_in.ready)
            begin
                if (pix_in.valid && pix_in.ready)
                    void'(pending_pix.pop_front());
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    pix_in.valid <= 1'b0;
                end
                else if (pending_pix.size() > 0 && !(pix_in.valid && pix_in.ready
                         && pending_pix.size() == 0))
                begin
                    pix_in.valid <= 1'b1;
                    pix_in.data <= pending_pix[0];
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    pix_in.valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern plus a long hold-off on request
    int stall_phase = 0;
    initial pix_out.ready = 1'b0;
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            pix_out.ready <= 1'b0;
        else
        begin
            stall_phase <= (stall_phase + 1) % 64;
            if (stall_phase < 24)
                pix_out.ready <= 1'b1;
            else
                pix_out.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        pix_t exp_px;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (expected_pix.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", pix_out.data);
            end
            else
            begin
                exp_px = expected_pix.pop_front();
                if (exp_px !== pix_out.data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp b=%0d g=%0d r=%0d l=%0d, got %0d %0d %0d %0d",
                                 exp_px.blue, exp_px.green, exp_px.red, exp_px.last,
                                 pix_out.data.blue, pix_out.data.green, pix_out.data.red,
                                 pix_out.data.last);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request or result while work is pending
    always @(posedge clk)
    begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) || hold_off
            || !rst_n)
            idle_cycles <= 0;
        else if (pending_pix.size() > 0 || expected_pix.size() > 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
            timed_out <= 1'b1;
    end

    function automatic pix_t rand_pix();
        pix_t px;
        px.blue = 8'($urandom_range(0, 255));
        px.green = 8'($urandom_range(0, 255));
        px.red = 8'($urandom_range(0, 255));
        px.last = ($urandom_range(0, 15) == 0);
        case ($urandom_range(0, 9))
            0: begin px.green = px.blue; px.red = px.blue; end
            1: px.green = px.blue;
            2: begin px.red = 8'd255; px.blue = 8'd0; end
            default: ;
        endcase
        return px;
    endfunction

    task automatic wait_idle();
        while (pending_pix.size() > 0 || pix_in.valid || expected_pix.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_hue(logic [HUE_W-1:0] hue);
        cfg_we <= 1'b1;
        cfg_wdata <= hue;
        hue_reg <= hue;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stimulus and end of run
    logic [HUE_W-1:0] hues[8] = '{9'd0, 9'd360, 9'd511, 9'd120,
                                  9'd240, 9'd59, 9'd300, 9'd361};
    initial
    begin
        pix_t px;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed corners at reset hue
        pending_pix.push_back('{8'd0, 8'd0, 8'd0, 1'b0});
        pending_pix.push_back('{8'd255, 8'd255, 8'd255, 1'b1});
        pending_pix.push_back('{8'd128, 8'd128, 8'd128, 1'b0});
        pending_pix.push_back('{8'd0, 8'd0, 8'd255, 1'b0});
        pending_pix.push_back('{8'd0, 8'd255, 8'd0, 1'b0});
        pending_pix.push_back('{8'd255, 8'd0, 8'd0, 1'b1});
        pending_pix.push_back('{8'd255, 8'd254, 8'd255, 1'b0});
        pending_pix.push_back('{8'd1, 8'd0, 8'd0, 1'b0});
        pending_pix.push_back('{8'd255, 8'd0, 8'd255, 1'b0});
        pending_pix.push_back('{8'd170, 8'd85, 8'd85, 1'b1});
        wait_idle();
        // random phases across hue settings
        for (int ph = 0; ph < 8 && !timed_out; ph++)
        begin
            set_hue((ph == 7) ? 9'($urandom_range(0, 511)) : hues[ph]);
            for (int i = 0; i < 140; i++)
                pending_pix.push_back(rand_pix());
            if (ph == 2)
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_idle();
        end
        if (timed_out || mismatches > 0 || expected_pix.size() > 0)
            $display("** pixel_hue_replace: FAILED **");
        else
            $display("** pixel_hue_replace: PASSED **");
        $finish;
    end

    // Timeout path
    initial
    begin
        wait (timed_out);
        $display("** pixel_hue_replace: FAILED **");
        $finish;
    end
endmodule
